// File: rtl/indexed_insert_remove_list_assert.svh
// Assertion macros used by the list top module.
`ifndef INDEXED_INSERT_REMOVE_LIST_ASSERT_SVH
`define INDEXED_INSERT_REMOVE_LIST_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IIRL_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("iirl assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define IIRL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("iirl assertion failed");

`endif

// File: rtl/iirl_pkg.sv
// Shared widths, codes and types of the indexed insert/remove list.
package iirl_pkg;

    localparam int DATA_W       = 32;
    localparam int KIND_W       = 3;
    localparam int POS_W        = 4;
    localparam int COUNT_W      = 5;
    localparam int STATUS_W     = 2;
    localparam int CAPACITY_DEF = 16;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_HEAD   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TAIL   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd5;

    // response status
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // operation broadcast to every cell
    typedef enum logic [2:0] {
        OP_NONE,
        OP_WRITE,
        OP_INSERT,
        OP_HEAD,
        OP_TAIL,
        OP_REMOVE
    } t_op;

    typedef struct packed {
        t_op                      op;
        logic signed [DATA_W-1:0] value;
    } t_cmd;

endpackage

// File: rtl/iirl_if.sv
// Request and response channel interfaces of the list.
interface iirl_req_if;
    logic                                   valid;
    logic                                   ready;
    logic [iirl_pkg::KIND_W-1:0]            kind;
    logic [iirl_pkg::POS_W-1:0]             position;
    logic signed [iirl_pkg::DATA_W-1:0]     value;

    modport source (output valid, kind, position, value, input ready);
    modport sink   (input valid, kind, position, value, output ready);
endinterface

interface iirl_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [iirl_pkg::DATA_W-1:0]     word;
    logic [iirl_pkg::COUNT_W-1:0]           count;
    logic [iirl_pkg::STATUS_W-1:0]          status;

    modport source (output valid, word, count, status, input ready);
    modport sink   (input valid, word, count, status, output ready);
endinterface

// File: rtl/iirl_cell.sv
// One list entry: holds, loads, or takes its lower or upper neighbor's word.
module iirl_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                               i_clk,
    input  iirl_pkg::t_cmd                     i_cmd,
    input  logic [CW-1:0]                      i_pos,
    input  logic [CW-1:0]                      i_fill,
    input  logic signed [iirl_pkg::DATA_W-1:0] i_lower,
    input  logic signed [iirl_pkg::DATA_W-1:0] i_upper,
    output logic signed [iirl_pkg::DATA_W-1:0] o_data
);

    localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
    localparam logic [CW:0]   MY_NEXT = (CW+1)'(IDX + 1);

    logic signed [iirl_pkg::DATA_W-1:0] r_data;
    logic signed [iirl_pkg::DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_cmd.op)
            iirl_pkg::OP_WRITE: begin
                if (MY_IDX == i_pos) n_data = i_cmd.value;
            end
            iirl_pkg::OP_INSERT: begin
                if (MY_IDX == i_pos) begin
                    n_data = i_cmd.value;
                end else if (MY_IDX > i_pos && MY_IDX <= i_fill) begin
                    n_data = i_lower;
                end
            end
            iirl_pkg::OP_HEAD: begin
                if (MY_IDX == '0) begin
                    n_data = i_cmd.value;
                end else if (MY_IDX <= i_fill) begin
                    n_data = i_lower;
                end
            end
            iirl_pkg::OP_TAIL: begin
                if (MY_IDX == i_fill) n_data = i_cmd.value;
            end
            iirl_pkg::OP_REMOVE: begin
                if (MY_IDX >= i_pos && MY_NEXT < {1'b0, i_fill}) n_data = i_upper;
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// File: rtl/indexed_insert_remove_list.sv
// Indexed insert/remove list: a row of entry cells that shift as one.
// A response word is registered, valid in the cycle after its request is accepted.
// One request per cycle unless stalled; all cells shift in the request's own cycle.
// Request ready falls only while a finished response waits on a stalled output register.
// Reset (i_rst_n low, synchronous) empties the list and drops any pending response;
// entry contents are undefined until written and need no clearing pass.
module indexed_insert_remove_list #(
    parameter int CAPACITY = iirl_pkg::CAPACITY_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    iirl_req_if.sink       i_req,
    iirl_rsp_if.source     o_rsp
);

    `include "indexed_insert_remove_list_assert.svh"

    // fill counts 0..CAPACITY; compares run at the wider of fill and position
    localparam int FW   = $clog2(CAPACITY + 1);
    localparam int CW   = (FW > iirl_pkg::POS_W) ? FW : iirl_pkg::POS_W;
    // position reaches at most 15, so only the low cells are ever read
    localparam int RD_N = (CAPACITY < (1 << iirl_pkg::POS_W)) ? CAPACITY
                                                             : (1 << iirl_pkg::POS_W);

    logic [FW-1:0]                          r_fill;
    logic [FW-1:0]                          n_fill;
    logic                                   r_vld;
    logic signed [iirl_pkg::DATA_W-1:0]     r_word;
    logic signed [iirl_pkg::DATA_W-1:0]     n_word;
    logic [iirl_pkg::STATUS_W-1:0]          r_status;
    logic [iirl_pkg::STATUS_W-1:0]          n_status;

    logic                                   acc;
    logic [CW-1:0]                          pos_c;
    logic [CW-1:0]                          fill_c;
    logic                                   in_range;
    logic                                   full;
    logic                                   grow;
    logic                                   shrink;
    iirl_pkg::t_op                          op;
    iirl_pkg::t_cmd                         cmd;
    logic signed [iirl_pkg::DATA_W-1:0]     rd_word;
    logic signed [iirl_pkg::DATA_W-1:0]     cell_data [CAPACITY];

    // Take a new request whenever the output register is empty or being drained.
    assign i_req.ready = !r_vld || o_rsp.ready;
    assign acc         = i_req.valid && i_req.ready;

    assign pos_c    = CW'(i_req.position);
    assign fill_c   = CW'(r_fill);
    assign in_range = pos_c < fill_c;
    assign full     = r_fill == FW'(CAPACITY);

    // Read tap: pick the addressed cell among the readable ones.
    always_comb begin
        rd_word = '0;
        for (int i = 0; i < RD_N; i++) begin
            if (i_req.position == iirl_pkg::POS_W'(i)) rd_word = cell_data[i];
        end
    end

    // Decode the request: status, word returned, cell operation, fill change.
    // A rejected request leaves every cell and the fill untouched.
    always_comb begin
        op       = iirl_pkg::OP_NONE;
        n_status = iirl_pkg::ST_OK;
        n_word   = '0;
        grow     = 1'b0;
        shrink   = 1'b0;
        case (i_req.kind)
            iirl_pkg::KIND_READ: begin
                if (!in_range) n_status = iirl_pkg::ST_RANGE;
                else n_word = rd_word;
            end
            iirl_pkg::KIND_WRITE: begin
                if (!in_range) n_status = iirl_pkg::ST_RANGE;
                else op = iirl_pkg::OP_WRITE;
            end
            iirl_pkg::KIND_INSERT: begin
                // index check ranks ahead of the full check
                if (!in_range) begin
                    n_status = iirl_pkg::ST_RANGE;
                end else if (full) begin
                    n_status = iirl_pkg::ST_FULL;
                end else begin
                    op   = iirl_pkg::OP_INSERT;
                    grow = 1'b1;
                end
            end
            iirl_pkg::KIND_HEAD: begin
                if (full) begin
                    n_status = iirl_pkg::ST_FULL;
                end else begin
                    op   = iirl_pkg::OP_HEAD;
                    grow = 1'b1;
                end
            end
            iirl_pkg::KIND_TAIL: begin
                if (full) begin
                    n_status = iirl_pkg::ST_FULL;
                end else begin
                    op   = iirl_pkg::OP_TAIL;
                    grow = 1'b1;
                end
            end
            iirl_pkg::KIND_REMOVE: begin
                if (!in_range) begin
                    n_status = iirl_pkg::ST_RANGE;
                end else begin
                    op     = iirl_pkg::OP_REMOVE;
                    n_word = rd_word;
                    shrink = 1'b1;
                end
            end
            default: begin
                // unused kinds answer the current count with status ok
                op = iirl_pkg::OP_NONE;
            end
        endcase
    end

    // Broadcast the operation only on an accepted request.
    assign cmd.op    = acc ? op : iirl_pkg::OP_NONE;
    assign cmd.value = i_req.value;

    always_comb begin
        n_fill = r_fill;
        if (acc && grow) n_fill = r_fill + 1'b1;
        else if (acc && shrink) n_fill = r_fill - 1'b1;
    end

    // Row of entry cells; each hands its word to both neighbors every cycle.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        iirl_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_pos   (pos_c),
            .i_fill  (fill_c),
            .i_lower (cell_data[(g == 0) ? 0 : g - 1]),
            .i_upper (cell_data[(g == CAPACITY - 1) ? CAPACITY - 1 : g + 1]),
            .o_data  (cell_data[g])
        );
    end

    // Fill counter and response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_vld  <= 1'b0;
        end else begin
            r_fill <= n_fill;
            if (acc) r_vld <= 1'b1;
            else if (o_rsp.ready) r_vld <= 1'b0;
        end
        if (acc) begin
            r_word   <= n_word;
            r_status <= n_status;
        end
    end

    // count follows the fill after the request it answers
    logic [iirl_pkg::COUNT_W-1:0] r_count;
    always_ff @(posedge i_clk) begin
        if (acc) r_count <= iirl_pkg::COUNT_W'(n_fill);
    end

    assign o_rsp.valid  = r_vld;
    assign o_rsp.word   = r_word;
    assign o_rsp.count  = r_count;
    assign o_rsp.status = r_status;

    `IIRL_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FW'(CAPACITY))
    `IIRL_ASSERT_NEXT(a_fill_grow, i_clk, i_rst_n, acc && grow, r_fill == $past(r_fill) + 1'b1)
    `IIRL_ASSERT_NEXT(a_reject_hold, i_clk, i_rst_n, acc && n_status != iirl_pkg::ST_OK, $stable(r_fill))
    `IIRL_ASSERT_NOW(a_reject_zero, i_clk, i_rst_n, r_vld && r_status != iirl_pkg::ST_OK, r_word == '0)

endmodule

// File: bench/tb.sv
// Self-checking bench for the indexed insert/remove list, with its own list predictor.
`timescale 1ns / 100ps

module tb;

    localparam int CAP              = iirl_pkg::CAPACITY_DEF;
    // kinds the block must answer as no-ops
    localparam logic [iirl_pkg::KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [iirl_pkg::KIND_W-1:0] KIND_SPARE_HI = 3'd7;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int STALL_LIMIT      = 4000;
    localparam int RANDOM_PER_PHASE = 490;
    localparam int DRAIN_CYCLES     = 8;
    localparam int REPORT_MAX       = 10;

    typedef struct packed {
        logic signed [iirl_pkg::DATA_W-1:0] word;
        logic [iirl_pkg::COUNT_W-1:0]       count;
        logic [iirl_pkg::STATUS_W-1:0]      status;
    } t_list_rsp;

    // one request word; typed rows carry an expectation read off by hand
    typedef struct {
        logic [iirl_pkg::KIND_W-1:0]        kind;
        logic [iirl_pkg::POS_W-1:0]         position;
        logic signed [iirl_pkg::DATA_W-1:0] value;
        bit                                 typed;
        t_list_rsp                          rsp;
    } t_req_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    iirl_req_if req_if();
    iirl_rsp_if rsp_if();

    indexed_insert_remove_list #(
        .CAPACITY(CAP)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: the list contents and its fill, as the block holds them.
    // ------------------------------------------------------------------
    logic signed [iirl_pkg::DATA_W-1:0] list_words [CAP];
    int                                 list_fill;

    t_list_rsp awaited_rsp [$];
    t_req_row  stim_rows [$];

    int  req_idle_pct   = 0;
    int  rsp_stall_pct  = 0;
    bit  hold_off_wanted = 1'b0;

    int  fault_count     = 0;
    int  checked_count   = 0;
    int  sent_count      = 0;
    int  directed_count  = 0;
    int  peak_fill       = 0;
    int  range_rejects   = 0;
    int  full_rejects    = 0;
    int  quiet_cycles    = 0;

    // Apply one request to the predicted list and return the response it earns.
    // A rejected request leaves the list untouched.
    function automatic t_list_rsp apply_list_request(logic [iirl_pkg::KIND_W-1:0] kind,
                                                     logic [iirl_pkg::POS_W-1:0] pos,
                                                     logic signed [iirl_pkg::DATA_W-1:0] val);
        t_list_rsp r;
        int        i;
        bit        in_range;
        bit        full;
        r.word   = '0;
        r.status = iirl_pkg::ST_OK;
        in_range = (int'(pos) < list_fill);
        full     = (list_fill >= CAP);
        case (kind)
            iirl_pkg::KIND_READ: begin
                if (!in_range) r.status = iirl_pkg::ST_RANGE;
                else r.word = list_words[pos];
            end
            iirl_pkg::KIND_WRITE: begin
                if (!in_range) r.status = iirl_pkg::ST_RANGE;
                else list_words[pos] = val;
            end
            iirl_pkg::KIND_INSERT: begin
                // index check wins over the full check
                if (!in_range) begin
                    r.status = iirl_pkg::ST_RANGE;
                end else if (full) begin
                    r.status = iirl_pkg::ST_FULL;
                end else begin
                    for (i = list_fill; i > int'(pos); i--) list_words[i] = list_words[i-1];
                    list_words[pos] = val;
                    list_fill++;
                end
            end
            iirl_pkg::KIND_HEAD: begin
                if (full) begin
                    r.status = iirl_pkg::ST_FULL;
                end else begin
                    for (i = list_fill; i > 0; i--) list_words[i] = list_words[i-1];
                    list_words[0] = val;
                    list_fill++;
                end
            end
            iirl_pkg::KIND_TAIL: begin
                if (full) begin
                    r.status = iirl_pkg::ST_FULL;
                end else begin
                    list_words[list_fill] = val;
                    list_fill++;
                end
            end
            iirl_pkg::KIND_REMOVE: begin
                if (!in_range) begin
                    r.status = iirl_pkg::ST_RANGE;
                end else begin
                    r.word = list_words[pos];
                    for (i = int'(pos); i + 1 < list_fill; i++) list_words[i] = list_words[i+1];
                    list_fill--;
                end
            end
            default: ;  // spare kinds: no change, status ok
        endcase
        r.count = iirl_pkg::COUNT_W'(list_fill);
        return r;
    endfunction

    function automatic string rsp_text(t_list_rsp r);
        return $sformatf("word=%h count=%0d status=%0d", r.word, r.count, r.status);
    endfunction

    function automatic void put_row(logic [iirl_pkg::KIND_W-1:0] kind,
                                    logic [iirl_pkg::POS_W-1:0] pos,
                                    logic signed [iirl_pkg::DATA_W-1:0] val);
        t_req_row row;
        row.kind     = kind;
        row.position = pos;
        row.value    = val;
        row.typed    = 1'b0;
        row.rsp      = '0;
        stim_rows.push_back(row);
    endfunction

    function automatic void put_typed(logic [iirl_pkg::KIND_W-1:0] kind,
                                      logic [iirl_pkg::POS_W-1:0] pos,
                                      logic signed [iirl_pkg::DATA_W-1:0] val,
                                      logic signed [iirl_pkg::DATA_W-1:0] w, int c,
                                      logic [iirl_pkg::STATUS_W-1:0] s);
        t_req_row row;
        row.kind       = kind;
        row.position   = pos;
        row.value      = val;
        row.typed      = 1'b1;
        row.rsp.word   = w;
        row.rsp.count  = iirl_pkg::COUNT_W'(c);
        row.rsp.status = s;
        stim_rows.push_back(row);
    endfunction

    task automatic note_fault(string msg);
        fault_count++;
        if (fault_count <= REPORT_MAX) $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    // Offer one request word, idling first at the current rate, and hold it until
    // accepted. Predict on acceptance so the expectation queue follows accept order.
    task automatic send_request(t_req_row row);
        t_list_rsp predicted;
        while ($urandom_range(99) < req_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.kind     <= row.kind;
        req_if.position <= row.position;
        req_if.value    <= row.value;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predicted = apply_list_request(row.kind, row.position, row.value);
        awaited_rsp.push_back(row.typed ? row.rsp : predicted);
        sent_count++;
        if (predicted.status == iirl_pkg::ST_RANGE) range_rejects++;
        if (predicted.status == iirl_pkg::ST_FULL) full_rejects++;
        if (list_fill > peak_fill) peak_fill = list_fill;
    endtask

    // Random requests shaped to sweep the fill up to full and back to empty:
    // a growth bias flips near the ends, so full and empty stores are hit often.
    task automatic send_random_burst(int n);
        t_req_row row;
        bit       growing;
        int       k;
        int unsigned r;
        growing = 1'b1;
        for (k = 0; k < n; k++) begin
            if (list_fill == CAP && $urandom_range(3) == 0) growing = 1'b0;
            if (list_fill == 0 && $urandom_range(3) == 0) growing = 1'b1;
            if ($urandom_range(63) == 0) growing = !growing;
            r = $urandom_range(99);
            if (r < 15)                       row.kind = iirl_pkg::KIND_READ;
            else if (r < 25)                  row.kind = iirl_pkg::KIND_WRITE;
            else if (r < (growing ? 45 : 32)) row.kind = iirl_pkg::KIND_INSERT;
            else if (r < (growing ? 60 : 38)) row.kind = iirl_pkg::KIND_HEAD;
            else if (r < (growing ? 80 : 45)) row.kind = iirl_pkg::KIND_TAIL;
            else if (r < 97)                  row.kind = iirl_pkg::KIND_REMOVE;
            else row.kind = $urandom_range(1) ? KIND_SPARE_HI : KIND_SPARE_LO;
            // mostly in-range indexes, the rest anywhere in the field
            if (list_fill > 0 && $urandom_range(7) != 0)
                row.position = iirl_pkg::POS_W'($urandom_range(list_fill - 1));
            else
                row.position = iirl_pkg::POS_W'($urandom_range(15));
            case ($urandom_range(15))
                0:       row.value = 32'sh7fff_ffff;
                1:       row.value = 32'sh8000_0000;
                2:       row.value = '0;
                3:       row.value = -32'sd1;
                default: row.value = $urandom;
            endcase
            row.typed = 1'b0;
            row.rsp   = '0;
            send_request(row);
        end
    endtask

    // ------------------------------------------------------------------
    // Response side: drop ready at the phase rate, or hold it low for a long
    // stretch on request so the block backs up and stalls its input.
    // ------------------------------------------------------------------
    initial begin : rsp_drain
        int n;
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_wanted) begin
                hold_off_wanted = 1'b0;
                rsp_if.ready <= 1'b0;
                for (n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge i_clk);
            end
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    // Check every accepted response word against the oldest expectation.
    always @(posedge i_clk) begin : rsp_check
        t_list_rsp want;
        t_list_rsp got;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got.word   = rsp_if.word;
            got.count  = rsp_if.count;
            got.status = rsp_if.status;
            if (awaited_rsp.size() == 0) begin
                note_fault($sformatf("unexpected response %s", rsp_text(got)));
            end else begin
                want = awaited_rsp.pop_front();
                checked_count++;
                if (got !== want)
                    note_fault($sformatf("response %0d: expected %s, got %s",
                                         checked_count, rsp_text(want), rsp_text(got)));
            end
        end
    end

    // Watchdog: end the run if no word moves on either channel for too long.
    always @(posedge i_clk) begin : stall_watch
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[%0t] watchdog: %0d quiet cycles, %0d responses outstanding",
                     $realtime, STALL_LIMIT, awaited_rsp.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table, four idle/stall phases, drain.
    // ------------------------------------------------------------------
    initial begin : main_seq
        int i;
        int ph;
        int idle_plan  [4];
        int stall_plan [4];
        logic [iirl_pkg::KIND_W-1:0] fill_kind;
        idle_plan  = '{0, 88, 0, 14};
        stall_plan = '{0, 0, 88, 14};

        req_if.valid    = 1'b0;
        req_if.kind     = iirl_pkg::KIND_READ;
        req_if.position = '0;
        req_if.value    = '0;
        list_fill       = 0;
        for (i = 0; i < CAP; i++) list_words[i] = '0;

        // Directed table. Empty store first: read, remove and insert are out of range,
        // and insert cannot append at the fill position.
        put_typed(iirl_pkg::KIND_READ,   4'd0, 32'sd5, 32'sd0, 0, iirl_pkg::ST_RANGE);
        put_typed(iirl_pkg::KIND_REMOVE, 4'd0, 32'sd0, 32'sd0, 0, iirl_pkg::ST_RANGE);
        put_typed(iirl_pkg::KIND_INSERT, 4'd0, 32'sd9, 32'sd0, 0, iirl_pkg::ST_RANGE);
        put_typed(iirl_pkg::KIND_TAIL,   4'd0, 32'sh7fff_ffff, 32'sd0, 1, iirl_pkg::ST_OK);
        put_typed(iirl_pkg::KIND_HEAD,   4'd15, 32'sh8000_0000, 32'sd0, 2, iirl_pkg::ST_OK);
        put_typed(iirl_pkg::KIND_READ,   4'd1, 32'sd0, 32'sh7fff_ffff, 2, iirl_pkg::ST_OK);
        // spare kinds answer zero, the count and ok
        put_typed(KIND_SPARE_LO, 4'd0, 32'sd1, 32'sd0, 2, iirl_pkg::ST_OK);
        put_typed(KIND_SPARE_HI, 4'd15, -32'sd1, 32'sd0, 2, iirl_pkg::ST_OK);
        put_typed(iirl_pkg::KIND_WRITE,  4'd2, 32'sd3, 32'sd0, 2, iirl_pkg::ST_RANGE);
        put_typed(iirl_pkg::KIND_READ,   4'd15, 32'sd0, 32'sd0, 2, iirl_pkg::ST_RANGE);
        // fill to capacity through every growing kind
        for (i = 0; i < CAP - 2; i++) begin
            if (i % 3 == 0) fill_kind = iirl_pkg::KIND_HEAD;
            else if (i % 3 == 1) fill_kind = iirl_pkg::KIND_INSERT;
            else fill_kind = iirl_pkg::KIND_TAIL;
            put_row(fill_kind, iirl_pkg::POS_W'(i / 2), 32'sh1000_0000 + i);
        end
        // full store: every growing kind is refused
        put_typed(iirl_pkg::KIND_TAIL,   4'd0, 32'sd1, 32'sd0, CAP, iirl_pkg::ST_FULL);
        put_typed(iirl_pkg::KIND_HEAD,   4'd0, 32'sd1, 32'sd0, CAP, iirl_pkg::ST_FULL);
        put_typed(iirl_pkg::KIND_INSERT, 4'd15, 32'sd1, 32'sd0, CAP, iirl_pkg::ST_FULL);
        put_typed(iirl_pkg::KIND_WRITE,  4'd15, 32'sh7fff_ffff, 32'sd0, CAP, iirl_pkg::ST_OK);
        put_typed(iirl_pkg::KIND_READ,   4'd15, 32'sd0, 32'sh7fff_ffff, CAP, iirl_pkg::ST_OK);
        put_typed(iirl_pkg::KIND_REMOVE, 4'd15, 32'sd0, 32'sh7fff_ffff, CAP - 1,
                  iirl_pkg::ST_OK);
        put_row(iirl_pkg::KIND_REMOVE, 4'd0, 32'sd0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[k]) send_request(stim_rows[k]);
        directed_count = sent_count;

        for (ph = 0; ph < 4; ph++) begin
            req_idle_pct  = idle_plan[ph];
            rsp_stall_pct = stall_plan[ph];
            // back-pressure burst while the sender keeps offering at full rate
            if (ph == 0) hold_off_wanted = 1'b1;
            send_random_burst(RANDOM_PER_PHASE);
        end
        req_if.valid <= 1'b0;

        // drain outstanding responses, then watch for stray responses
        while (awaited_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests (%0d from the directed table), checked %0d responses.",
                 sent_count, directed_count, checked_count);
        $display("Fill peaked at %0d; %0d index rejects, %0d full rejects, %0d mismatches.",
                 peak_fill, range_rejects, full_rejects, fault_count);
        if (fault_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/iirl_pkg.sv
rtl/iirl_if.sv
rtl/iirl_cell.sv
rtl/indexed_insert_remove_list.sv
bench/tb.sv
